### sv/cca_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cca_pkg
// Shared types and constants of the cluster chain allocator.
// ----------------------------------------------------------------------------
package cca_pkg;

    localparam int FUNC_W    = 3;
    localparam int CLUSTER_W = 32;
    localparam int WANT_W    = 16;
    localparam int STATUS_W  = 2;
    localparam int READ_W    = 28;
    localparam int FIRST_W   = 12;
    localparam int FREE_W    = 13;
    localparam int CCOUNT_W  = 12;
    localparam int PROBE_W   = 13;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 12'd4094;

    localparam logic [31:0] ENTRY_MASK   = 32'h0FFF_FFFF;
    localparam logic [31:0] EOC_MARK     = 32'h0FFF_FFFF;
    localparam logic [31:0] EOC_MIN      = 32'h0FFF_FFF8;
    localparam logic [31:0] FIRST_DATA   = 32'd2;

    localparam logic [FUNC_W-1:0] FN_READ  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_WRITE = 3'd1;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd2;
    localparam logic [FUNC_W-1:0] FN_FREE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_COUNT = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOSPACE = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_A_PROBE,
        S_A_TEST,
        S_A_EOC,
        S_A_LINK,
        S_F_PROBE,
        S_F_TEST,
        S_C_RUN,
        S_C_LAST,
        S_RESP
    } state_t;

endpackage
`default_nettype wire

### sv/cca_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cca_ram
// Single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module cca_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

### sv/cluster_chain_allocator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cluster_chain_allocator
// Cluster link table with read, write, run allocate, chain free and free count.
// ----------------------------------------------------------------------------
// Flow: allocate probes for a free run, writes the end mark and links the run
//   backward; free clears each link of the chain; count scans for zero entries.
// Throughput: one request at a time; every walk goes through the single
//   table RAM port, one entry access per cycle.
// Reset: a clearing pass writes zero to all TABLE_DEPTH entries before in_ready
//   rises; config writes are taken throughout.
// ----------------------------------------------------------------------------
module cluster_chain_allocator #(
    parameter int TABLE_DEPTH = cca_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [cca_pkg::FUNC_W-1:0]         func,
    input  wire logic [cca_pkg::CLUSTER_W-1:0]      cluster,
    input  wire logic [cca_pkg::CLUSTER_W-1:0]      write_value,
    input  wire logic [cca_pkg::WANT_W-1:0]         alloc_count,
    // result channel
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [cca_pkg::STATUS_W-1:0]       status,
    output logic      [cca_pkg::READ_W-1:0]         read_value,
    output logic      [cca_pkg::FIRST_W-1:0]        first_cluster,
    output logic      [cca_pkg::FREE_W-1:0]         free_count,
    // cluster_count register
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [cca_pkg::CCOUNT_W-1:0]       cfg_data
);

    import cca_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [31:0] LAST_IDX = 32'(TABLE_DEPTH - 1);
    localparam logic [AW:0] DEPTH_CNT = (AW+1)'(TABLE_DEPTH);

    state_t state_reg, state_next;

    logic [CCOUNT_W-1:0]  ccount_reg;
    logic [31:0]          search_reg,  search_next;
    logic [FUNC_W-1:0]    func_reg,    func_next;
    logic [31:0]          cl_reg,      cl_next;      // request cluster / free walk pointer
    logic [31:0]          wv_reg,      wv_next;
    logic [WANT_W-1:0]    want_reg,    want_next;
    logic [31:0]          end_reg,     end_next;
    logic [31:0]          bgn_reg,     bgn_next;
    logic [PROBE_W-1:0]   n_reg,       n_next;
    logic [AW:0]          idx_reg,     idx_next;     // clear / count / free step index
    logic                 pend_reg,    pend_next;
    logic [FREE_W-1:0]    nfree_reg,   nfree_next;
    logic [STATUS_W-1:0]  rstat_reg,   rstat_next;
    logic [READ_W-1:0]    rread_reg,   rread_next;
    logic [FIRST_W-1:0]   rfirst_reg,  rfirst_next;
    logic                 ovalid_reg,  ovalid_next;
    logic [STATUS_W-1:0]  ostat_reg,   ostat_next;
    logic [READ_W-1:0]    oread_reg,   oread_next;
    logic [FIRST_W-1:0]   ofirst_reg,  ofirst_next;
    logic [FREE_W-1:0]    ofree_reg,   ofree_next;

    // table RAM port
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    logic [31:0]   mem_wdata;
    logic [31:0]   mem_rdata;

    cca_ram #(
        .WIDTH (32),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // last usable cluster, clipped to the table
    logic [31:0] ccp1;
    logic [31:0] last_cl;
    assign ccp1    = 32'(ccount_reg) + 32'd1;
    assign last_cl = (ccp1 > LAST_IDX) ? LAST_IDX : ccp1;

    // shared conditions
    logic        req_ok;       // request cluster in range
    logic [31:0] probe_end;    // allocate probe after wrap
    logic [31:0] probe_bgn;
    logic        probe_wrap;
    logic        probe_done;   // probe budget used up
    logic        probe_bad;
    logic        hit_used;
    logic        run_met;
    logic [31:0] walk_next;
    logic        out_free;

    assign req_ok     = (cl_reg >= FIRST_DATA) && (cl_reg <= last_cl);
    assign probe_wrap = end_reg > last_cl;
    assign probe_end  = probe_wrap ? FIRST_DATA : end_reg;
    assign probe_bgn  = probe_wrap ? FIRST_DATA : bgn_reg;
    assign probe_done = n_reg >= PROBE_W'(ccount_reg);
    assign probe_bad  = probe_end < FIRST_DATA;
    assign hit_used   = (mem_rdata & ENTRY_MASK) != 32'd0;
    assign run_met    = (end_reg - bgn_reg + 32'd1) == 32'(want_reg);
    assign walk_next  = mem_rdata & ENTRY_MASK;
    assign out_free   = !ovalid_reg || out_ready;

    assign in_ready      = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;
    assign out_valid     = ovalid_reg;
    assign status        = ostat_reg;
    assign read_value    = oread_reg;
    assign first_cluster = ofirst_reg;
    assign free_count    = ofree_reg;

    // ---------------------------------------------------------------- next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (idx_reg[AW-1:0] == AW'(TABLE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (func_reg)
                    FN_READ:  state_next = req_ok ? S_RD_WAIT : S_RESP;
                    FN_ALLOC: state_next = S_A_PROBE;
                    FN_FREE:  state_next = S_F_PROBE;
                    FN_COUNT: state_next = S_C_RUN;
                    default:  state_next = S_RESP;
                endcase
            end
            S_RD_WAIT: state_next = S_RESP;
            S_A_PROBE:
            begin
                if (probe_done || probe_bad)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_A_TEST;
                end
            end
            S_A_TEST:
            begin
                if (!hit_used && run_met)
                begin
                    state_next = S_A_EOC;
                end
                else
                begin
                    state_next = S_A_PROBE;
                end
            end
            S_A_EOC:  state_next = S_A_LINK;
            S_A_LINK:
            begin
                if (end_reg <= bgn_reg)
                begin
                    state_next = S_RESP;
                end
            end
            S_F_PROBE:
            begin
                if (idx_reg == DEPTH_CNT || !req_ok)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    state_next = S_F_TEST;
                end
            end
            S_F_TEST:
            begin
                state_next = (walk_next >= EOC_MIN) ? S_RESP : S_F_PROBE;
            end
            S_C_RUN:
            begin
                if (32'(idx_reg) == last_cl)
                begin
                    state_next = S_C_LAST;
                end
            end
            S_C_LAST: state_next = S_RESP;
            S_RESP:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        search_next = search_reg;
        func_next   = func_reg;
        cl_next     = cl_reg;
        wv_next     = wv_reg;
        want_next   = want_reg;
        end_next    = end_reg;
        bgn_next    = bgn_reg;
        n_next      = n_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        nfree_next  = nfree_reg;
        rstat_next  = rstat_reg;
        rread_next  = rread_reg;
        rfirst_next = rfirst_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ostat_next  = ostat_reg;
        oread_next  = oread_reg;
        ofirst_next = ofirst_reg;
        ofree_next  = ofree_reg;
        mem_we      = 1'b0;
        mem_addr    = cl_reg[AW-1:0];
        mem_wdata   = 32'd0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we   = 1'b1;
                mem_addr = idx_reg[AW-1:0];
                idx_next = idx_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    func_next   = func;
                    cl_next     = cluster;
                    wv_next     = write_value;
                    want_next   = alloc_count;
                    rstat_next  = ST_OK;
                    rread_next  = '0;
                    rfirst_next = '0;
                    nfree_next  = '0;
                end
            end
            S_DISPATCH:
            begin
                idx_next  = '0;
                n_next    = '0;
                pend_next = 1'b0;
                case (func_reg)
                    FN_READ:
                    begin
                        if (!req_ok)
                        begin
                            rstat_next = ST_BAD;
                        end
                    end
                    FN_WRITE:
                    begin
                        if (req_ok)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = wv_reg;
                        end
                        else
                        begin
                            rstat_next = ST_BAD;
                        end
                    end
                    FN_ALLOC:
                    begin
                        // cl_reg keeps the chain tail during the search
                        end_next = (cl_reg != 32'd0) ? cl_reg + 32'd1 : search_reg;
                        bgn_next = end_next;
                    end
                    FN_FREE:
                    begin
                        search_next = FIRST_DATA;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                rread_next = walk_next[READ_W-1:0];
            end
            S_A_PROBE:
            begin
                if (probe_done)
                begin
                    rstat_next = ST_NOSPACE;
                end
                else if (probe_bad)
                begin
                    rstat_next = ST_BAD;
                end
                else
                begin
                    mem_addr = probe_end[AW-1:0];
                    end_next = probe_end;
                    bgn_next = probe_bgn;
                end
            end
            S_A_TEST:
            begin
                if (hit_used)
                begin
                    bgn_next = end_reg + 32'd1;
                    n_next   = n_reg + 1'b1;
                    end_next = end_reg + 32'd1;
                end
                else if (!run_met)
                begin
                    n_next   = n_reg + 1'b1;
                    end_next = end_reg + 32'd1;
                end
            end
            S_A_EOC:
            begin
                mem_we    = 1'b1;
                mem_addr  = end_reg[AW-1:0];
                mem_wdata = EOC_MARK;
            end
            S_A_LINK:
            begin
                if (end_reg > bgn_reg)
                begin
                    // link backward: entry end-1 points at end
                    mem_we    = 1'b1;
                    mem_addr  = AW'(end_reg - 32'd1);
                    mem_wdata = end_reg;
                    end_next  = end_reg - 32'd1;
                end
                else if (cl_reg != 32'd0)
                begin
                    if (req_ok)
                    begin
                        mem_we      = 1'b1;
                        mem_wdata   = bgn_reg;
                        rfirst_next = bgn_reg[FIRST_W-1:0];
                    end
                    else
                    begin
                        rstat_next = ST_BAD;
                    end
                end
                else
                begin
                    rfirst_next = bgn_reg[FIRST_W-1:0];
                    if (want_reg == WANT_W'(1))
                    begin
                        search_next = bgn_reg + 32'd1;
                    end
                end
            end
            S_F_PROBE:
            begin
                if (idx_reg == DEPTH_CNT || !req_ok)
                begin
                    rstat_next = ST_BAD;
                end
            end
            S_F_TEST:
            begin
                mem_we   = 1'b1;
                cl_next  = walk_next;
                idx_next = idx_reg + 1'b1;
            end
            S_C_RUN:
            begin
                mem_addr  = idx_reg[AW-1:0];
                pend_next = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (pend_reg && mem_rdata == 32'd0)
                begin
                    nfree_next = nfree_reg + 1'b1;
                end
            end
            S_C_LAST:
            begin
                if (mem_rdata == 32'd0)
                begin
                    nfree_next = nfree_reg + 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    ostat_next  = rstat_reg;
                    oread_next  = rread_reg;
                    ofirst_next = rfirst_reg;
                    ofree_next  = nfree_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            ccount_reg <= CCOUNT_RESET;
            search_reg <= FIRST_DATA;
            idx_reg    <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            if (cfg_valid)
            begin
                ccount_reg <= cfg_data;
            end
            search_reg <= search_next;
            idx_reg    <= idx_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        cl_reg     <= cl_next;
        wv_reg     <= wv_next;
        want_reg   <= want_next;
        end_reg    <= end_next;
        bgn_reg    <= bgn_next;
        n_reg      <= n_next;
        nfree_reg  <= nfree_next;
        rstat_reg  <= rstat_next;
        rread_reg  <= rread_next;
        rfirst_reg <= rfirst_next;
        ostat_reg  <= ostat_next;
        oread_reg  <= oread_next;
        ofirst_reg <= ofirst_next;
        ofree_reg  <= ofree_next;
    end

    // ---------------------------------------------------------------- checks
    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted request not dispatched");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status != 2'd3))
        else $error("undefined status code");

    a_resp_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && out_free) |=> out_valid)
        else $error("result not presented");

endmodule
`default_nettype wire
